// ===== rtl/core/otx_pkg.sv =====
// Shared types and constants of the on-off-keyed pulse-width transmitter.
// Used by otx_front, otx_back and ook_pulse_width_transmitter; depends on nothing.
`default_nettype none

package otx_pkg;

   localparam int MAX_BITS    = 32;
   localparam int TICK_WIDTH  = 16;
   localparam int CODE_W      = 32;
   localparam int COUNT_W     = 6;
   localparam int REPEAT_W    = 16;
   localparam int UNIT_W      = 6;
   localparam int PULSE_W     = 16;
   localparam int BIT_IDX_W   = $clog2(MAX_BITS);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Input opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_TICK      = 2'd0;
   localparam logic [1:0] STATUS_ACCEPTED  = 2'd1;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;
   localparam logic [1:0] STATUS_BUSY      = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TICKS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_HIGH_UNITS = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_LOW_UNITS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH_UNITS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW_UNITS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH_UNITS = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW_UNITS  = 3'd6;

   typedef struct packed {
      logic                opcode;
      logic [CODE_W-1:0]   code_word;
      logic [COUNT_W-1:0]  bit_count;
      logic [REPEAT_W-1:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic       line_level;
      logic       busy_res;
      logic [1:0] status;
      logic       frame_done;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_START,
      CMD_BAD_COUNT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CODE_W-1:0]   code_word;
      logic [COUNT_W-1:0]  bit_count;
      logic [REPEAT_W-1:0] repeat_count;
   } cmd_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_ticks;
      logic [UNIT_W-1:0]  sync_high_units;
      logic [UNIT_W-1:0]  sync_low_units;
      logic [UNIT_W-1:0]  one_high_units;
      logic [UNIT_W-1:0]  one_low_units;
      logic [UNIT_W-1:0]  zero_high_units;
      logic [UNIT_W-1:0]  zero_low_units;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/otx_front.sv =====
// Front end: accepts request items, classifies them and holds them in a two-entry queue.
// Depends on otx_pkg.
`default_nettype none

module otx_front
   import otx_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    cmd_valid,
   input  wire     cmd_ready,
   output cmd_type cmd_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   cmd_type    classified;

   // The bit count is checked here; the busy check needs the engine state and stays behind.
   always_comb begin
      classified.code_word    = req_data.code_word;
      classified.bit_count    = req_data.bit_count;
      classified.repeat_count = req_data.repeat_count;
      if (req_data.opcode == OP_START) begin
         if (req_data.bit_count == '0 || req_data.bit_count > COUNT_W'(MAX_BITS)) begin
            classified.kind = CMD_BAD_COUNT;
         end else begin
            classified.kind = CMD_START;
         end
      end else begin
         classified.kind = CMD_TICK;
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue fill count out of range");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> count_ff == 2'd2)
      else $error("full queue lost an item");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// ===== rtl/core/otx_back.sv =====
// Back end: the frame engine that carries out queued items, and the result register.
// Depends on otx_pkg.
`default_nettype none

module otx_back
   import otx_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  cfg_type cfg,
   input  wire     cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd_data,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      PH_BIT_HIGH,
      PH_BIT_LOW,
      PH_SYNC_HIGH,
      PH_SYNC_LOW
   } phase_type;

   logic [CODE_W-1:0]     code_shift_ff, code_shift_in;
   logic [COUNT_W-1:0]    bits_left_ff, bits_left_in;
   logic [COUNT_W-1:0]    bits_total_ff, bits_total_in;
   phase_type             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [UNIT_W-1:0]     units_left_ff, units_left_in;
   logic [REPEAT_W-1:0]   repeats_left_ff, repeats_left_in;
   logic                  active_ff, active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  step;
   logic [PULSE_W-1:0]    pulse_min;
   logic [TICK_WIDTH-1:0] tick_limit, tick_next;
   logic [UNIT_W-1:0]     units_dec;
   logic [COUNT_W-1:0]    bits_dec, bits_dec2, count_dec, total_dec;
   logic [REPEAT_W-1:0]   repeats_dec;
   logic                  cur_bit, next_bit, start_bit, first_bit;
   logic [1:0]            status;
   logic                  done;

   function automatic logic [UNIT_W-1:0] at_least_one(input logic [UNIT_W-1:0] units);
      at_least_one = (units == '0) ? UNIT_W'(1) : units;
   endfunction

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign step      = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pulse_min   = (cfg.pulse_ticks == '0) ? PULSE_W'(1) : cfg.pulse_ticks;
   assign tick_limit  = TICK_WIDTH'(pulse_min);
   assign tick_next   = tick_count_ff + TICK_WIDTH'(1);
   assign units_dec   = units_left_ff - UNIT_W'(1);
   assign bits_dec    = bits_left_ff - COUNT_W'(1);
   assign bits_dec2   = bits_left_ff - COUNT_W'(2);
   assign count_dec   = cmd_data.bit_count - COUNT_W'(1);
   assign total_dec   = bits_total_ff - COUNT_W'(1);
   assign repeats_dec = repeats_left_ff - REPEAT_W'(1);
   assign cur_bit     = code_shift_ff[bits_dec[BIT_IDX_W-1:0]];
   assign next_bit    = code_shift_ff[bits_dec2[BIT_IDX_W-1:0]];
   assign start_bit   = cmd_data.code_word[count_dec[BIT_IDX_W-1:0]];
   assign first_bit   = code_shift_ff[total_dec[BIT_IDX_W-1:0]];

   always_comb begin
      code_shift_in   = code_shift_ff;
      bits_left_in    = bits_left_ff;
      bits_total_in   = bits_total_ff;
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      units_left_in   = units_left_ff;
      repeats_left_in = repeats_left_ff;
      active_in       = active_ff;
      status          = STATUS_TICK;
      done            = 1'b0;

      case (cmd_data.kind)
         CMD_BAD_COUNT: begin
            status = STATUS_BAD_COUNT;
         end
         CMD_START: begin
            if (active_ff) begin
               status = STATUS_BUSY;
            end else begin
               status = STATUS_ACCEPTED;
               if (cmd_data.repeat_count != '0) begin
                  code_shift_in   = cmd_data.code_word;
                  bits_total_in   = cmd_data.bit_count;
                  bits_left_in    = cmd_data.bit_count;
                  repeats_left_in = cmd_data.repeat_count;
                  active_in       = 1'b1;
                  tick_count_in   = '0;
                  phase_in        = PH_BIT_HIGH;
                  units_left_in   = at_least_one(start_bit ? cfg.one_high_units
                                                           : cfg.zero_high_units);
               end
            end
         end
         CMD_TICK: begin
            if (active_ff) begin
               if (tick_next >= tick_limit) begin
                  tick_count_in = '0;
                  units_left_in = units_dec;
                  if (units_dec == '0) begin
                     // The stretch is over: move on to the next one.
                     case (phase_ff)
                        PH_BIT_HIGH: begin
                           phase_in      = PH_BIT_LOW;
                           units_left_in = at_least_one(cur_bit ? cfg.one_low_units
                                                                : cfg.zero_low_units);
                        end
                        PH_BIT_LOW: begin
                           bits_left_in = bits_dec;
                           if (bits_dec != '0) begin
                              phase_in      = PH_BIT_HIGH;
                              units_left_in = at_least_one(next_bit ? cfg.one_high_units
                                                                    : cfg.zero_high_units);
                           end else begin
                              phase_in      = PH_SYNC_HIGH;
                              units_left_in = at_least_one(cfg.sync_high_units);
                           end
                        end
                        PH_SYNC_HIGH: begin
                           phase_in      = PH_SYNC_LOW;
                           units_left_in = at_least_one(cfg.sync_low_units);
                        end
                        PH_SYNC_LOW: begin
                           repeats_left_in = repeats_dec;
                           if (repeats_dec == '0) begin
                              active_in     = 1'b0;
                              phase_in      = PH_BIT_HIGH;
                              units_left_in = '0;
                              bits_left_in  = '0;
                              done          = 1'b1;
                           end else begin
                              bits_left_in  = bits_total_ff;
                              phase_in      = PH_BIT_HIGH;
                              units_left_in = at_least_one(first_bit ? cfg.one_high_units
                                                                     : cfg.zero_high_units);
                           end
                        end
                        default: begin
                           phase_in = PH_BIT_HIGH;
                        end
                     endcase
                  end
               end else begin
                  tick_count_in = tick_next;
               end
            end
         end
         default: begin
            status = STATUS_TICK;
         end
      endcase

      rsp_data_in.line_level = active_in && (phase_in == PH_BIT_HIGH || phase_in == PH_SYNC_HIGH);
      rsp_data_in.busy_res   = active_in;
      rsp_data_in.status     = status;
      rsp_data_in.frame_done = done;
      rsp_valid_in           = cmd_ready ? cmd_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_shift_ff   <= '0;
         bits_left_ff    <= '0;
         bits_total_ff   <= '0;
         phase_ff        <= PH_BIT_HIGH;
         tick_count_ff   <= '0;
         units_left_ff   <= '0;
         repeats_left_ff <= '0;
         active_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_data_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            code_shift_ff   <= code_shift_in;
            bits_left_ff    <= bits_left_in;
            bits_total_ff   <= bits_total_in;
            phase_ff        <= phase_in;
            tick_count_ff   <= tick_count_in;
            units_left_ff   <= units_left_in;
            repeats_left_ff <= repeats_left_in;
            active_ff       <= active_in;
            rsp_data_ff     <= rsp_data_in;
         end
      end
   end

   // The bit counter is only meaningful while data bits are going out; it is zero in sync.
   a_bits_in_range: assert property (@(posedge clock) disable iff (reset)
      (active_ff && (phase_ff == PH_BIT_HIGH || phase_ff == PH_BIT_LOW))
         |-> (bits_left_ff != '0 && bits_left_ff <= bits_total_ff))
      else $error("bit counter left its range while sending");

   a_units_track_active: assert property (@(posedge clock) disable iff (reset)
      active_ff == (units_left_ff != '0))
      else $error("unit counter disagrees with the active flag");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_done) |-> !rsp_data_ff.busy_res)
      else $error("last frame reported while still busy");

   a_idle_line_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.busy_res) |-> !rsp_data_ff.line_level)
      else $error("line high while idle");

endmodule

`default_nettype wire

// ===== rtl/core/ook_pulse_width_transmitter.sv =====
// Top level of the on-off-keyed pulse-width transmitter: configuration registers,
// front end and frame engine. Depends on otx_pkg, otx_front and otx_back.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  req_data (req_type)
//   rsp_     out        rsp_valid/rsp_ready  rsp_data (rsp_type)
//   csr_     in         csr_write_en         csr_index, csr_wdata
//
// Every item, tick or start, passes through the frame engine at one item per cycle while
// rsp_ready keeps the result register free; the item is written to a queue slot at
// acceptance and then reaches the result register, which holds its result.
// The two-entry queue lets requests keep arriving while a result waits to be taken.
// Reset clears the engine, the queue and the result register and loads the default
// timing registers; there is no clearing pass.
`default_nettype none

module ook_pulse_width_transmitter
   import otx_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output rsp_type               rsp_data,
   input  wire                   csr_write_en,
   input  wire [CSR_INDEX_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks     <= PULSE_W'(350);
         cfg_ff.sync_high_units <= UNIT_W'(1);
         cfg_ff.sync_low_units  <= UNIT_W'(31);
         cfg_ff.one_high_units  <= UNIT_W'(3);
         cfg_ff.one_low_units   <= UNIT_W'(1);
         cfg_ff.zero_high_units <= UNIT_W'(1);
         cfg_ff.zero_low_units  <= UNIT_W'(3);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PULSE_TICKS:     cfg_ff.pulse_ticks     <= csr_wdata[PULSE_W-1:0];
            CSR_SYNC_HIGH_UNITS: cfg_ff.sync_high_units <= csr_wdata[UNIT_W-1:0];
            CSR_SYNC_LOW_UNITS:  cfg_ff.sync_low_units  <= csr_wdata[UNIT_W-1:0];
            CSR_ONE_HIGH_UNITS:  cfg_ff.one_high_units  <= csr_wdata[UNIT_W-1:0];
            CSR_ONE_LOW_UNITS:   cfg_ff.one_low_units   <= csr_wdata[UNIT_W-1:0];
            CSR_ZERO_HIGH_UNITS: cfg_ff.zero_high_units <= csr_wdata[UNIT_W-1:0];
            CSR_ZERO_LOW_UNITS:  cfg_ff.zero_low_units  <= csr_wdata[UNIT_W-1:0];
            default: begin
               // Unused index: the write is ignored.
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   otx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   otx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== verif/tx_line_checker.sv =====
`timescale 1ns / 100ps
// Checker for the on-off-keyed pulse-width transmitter: predicts the line for every
// accepted item and compares each result taken from the rsp_ channel with it.
// Depends on otx_pkg only.

module tx_line_checker
   import otx_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  req_type               req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  rsp_type               rsp_data,
   input  wire                   csr_write_en,
   input  wire [CSR_INDEX_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output logic                  busy_predicted
);

   typedef enum logic [1:0] {
      ST_BIT_HIGH,
      ST_BIT_LOW,
      ST_SYNC_HIGH,
      ST_SYNC_LOW
   } stretch_type;

   localparam logic [PULSE_W-1:0] RESET_PULSE_TICKS = 16'd350;
   localparam logic [UNIT_W-1:0]  RESET_SYNC_HIGH   = 6'd1;
   localparam logic [UNIT_W-1:0]  RESET_SYNC_LOW    = 6'd31;
   localparam logic [UNIT_W-1:0]  RESET_ONE_HIGH    = 6'd3;
   localparam logic [UNIT_W-1:0]  RESET_ONE_LOW     = 6'd1;
   localparam logic [UNIT_W-1:0]  RESET_ZERO_HIGH   = 6'd1;
   localparam logic [UNIT_W-1:0]  RESET_ZERO_LOW    = 6'd3;

   cfg_type               timing;
   logic [CODE_W-1:0]     code_reg;
   logic [COUNT_W-1:0]    bits_rem;
   logic [COUNT_W-1:0]    bits_tot;
   stretch_type           stage;
   logic [TICK_WIDTH-1:0] tick_accum;
   logic [UNIT_W-1:0]     unit_count;
   logic [REPEAT_W-1:0]   frames_left;
   logic                  sending;
   rsp_type               expected_line_q[$];

   function automatic logic [UNIT_W-1:0] units_or_one(input logic [UNIT_W-1:0] v);
      return (v == 0) ? 6'd1 : v;
   endfunction

   function automatic logic [PULSE_W-1:0] ticks_or_one(input logic [PULSE_W-1:0] v);
      return (v == 0) ? 16'd1 : v;
   endfunction

   function logic code_bit();
      logic [COUNT_W-1:0] idx;
      idx = bits_rem - 1'b1;
      return (idx < CODE_W) ? code_reg[idx] : 1'b0;
   endfunction

   task load_bit();
      stage      = ST_BIT_HIGH;
      unit_count = units_or_one(code_bit() ? timing.one_high_units : timing.zero_high_units);
   endtask

   task load_frame();
      bits_rem   = bits_tot;
      tick_accum = '0;
      load_bit();
   endtask

   // Moves on to the next stretch; last is raised when the final frame has ended.
   task end_stretch(output logic last);
      last = 1'b0;
      case (stage)
         ST_BIT_HIGH: begin
            stage      = ST_BIT_LOW;
            unit_count = units_or_one(code_bit() ? timing.one_low_units
                                                 : timing.zero_low_units);
         end
         ST_BIT_LOW: begin
            bits_rem = bits_rem - 1'b1;
            if (bits_rem != 0) begin
               load_bit();
            end else begin
               stage      = ST_SYNC_HIGH;
               unit_count = units_or_one(timing.sync_high_units);
            end
         end
         ST_SYNC_HIGH: begin
            stage      = ST_SYNC_LOW;
            unit_count = units_or_one(timing.sync_low_units);
         end
         default: begin
            frames_left = frames_left - 1'b1;
            if (frames_left == 0) begin
               sending    = 1'b0;
               stage      = ST_BIT_HIGH;
               unit_count = '0;
               bits_rem   = '0;
               last       = 1'b1;
            end else begin
               load_frame();
            end
         end
      endcase
   endtask

   task predict_line(input req_type it, output rsp_type r);
      logic [1:0] st;
      logic       done;
      logic       last;
      st   = STATUS_TICK;
      done = 1'b0;
      if (it.opcode == OP_START) begin
         // The bit count is checked before the busy state.
         if (it.bit_count == 0 || it.bit_count > MAX_BITS) begin
            st = STATUS_BAD_COUNT;
         end else if (sending) begin
            st = STATUS_BUSY;
         end else begin
            st = STATUS_ACCEPTED;
            if (it.repeat_count != 0) begin
               code_reg    = it.code_word;
               bits_tot    = it.bit_count;
               frames_left = it.repeat_count;
               sending     = 1'b1;
               load_frame();
            end
         end
      end else if (sending) begin
         tick_accum = tick_accum + 1'b1;
         if (tick_accum >= ticks_or_one(timing.pulse_ticks)) begin
            tick_accum = '0;
            unit_count = unit_count - 1'b1;
            if (unit_count == 0) begin
               end_stretch(last);
               done = last;
            end
         end
      end
      r.line_level = sending && (stage == ST_BIT_HIGH || stage == ST_SYNC_HIGH);
      r.busy_res   = sending;
      r.status     = st;
      r.frame_done = done;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         timing = '{pulse_ticks: RESET_PULSE_TICKS, sync_high_units: RESET_SYNC_HIGH,
                    sync_low_units: RESET_SYNC_LOW, one_high_units: RESET_ONE_HIGH,
                    one_low_units: RESET_ONE_LOW, zero_high_units: RESET_ZERO_HIGH,
                    zero_low_units: RESET_ZERO_LOW};
         code_reg       = '0;
         bits_rem       = '0;
         bits_tot       = '0;
         stage          = ST_BIT_HIGH;
         tick_accum     = '0;
         unit_count     = '0;
         frames_left    = '0;
         sending        = 1'b0;
         mismatch_count = 0;
         expected_line_q.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PULSE_TICKS:     timing.pulse_ticks     = csr_wdata;
               CSR_SYNC_HIGH_UNITS: timing.sync_high_units = csr_wdata[UNIT_W-1:0];
               CSR_SYNC_LOW_UNITS:  timing.sync_low_units  = csr_wdata[UNIT_W-1:0];
               CSR_ONE_HIGH_UNITS:  timing.one_high_units  = csr_wdata[UNIT_W-1:0];
               CSR_ONE_LOW_UNITS:   timing.one_low_units   = csr_wdata[UNIT_W-1:0];
               CSR_ZERO_HIGH_UNITS: timing.zero_high_units = csr_wdata[UNIT_W-1:0];
               CSR_ZERO_LOW_UNITS:  timing.zero_low_units  = csr_wdata[UNIT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_line(req_data, want);
            expected_line_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (expected_line_q.size() == 0) begin
               $error("result arrived with no item waiting for it");
               mismatch_count++;
            end else begin
               want = expected_line_q.pop_front();
               if (got.line_level !== want.line_level) begin
                  $error("line_level: expected %0d, got %0d", want.line_level, got.line_level);
                  mismatch_count++;
               end
               if (got.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                  mismatch_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  mismatch_count++;
               end
               if (got.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count  = expected_line_q.size();
      busy_predicted = sending;
   end

endmodule

// ===== verif/tb_ook_pulse_width_transmitter.sv =====
`timescale 1ns / 100ps
// Top of the transmitter testbench: clock, reset, stimulus and verdict.
// Depends on otx_pkg, ook_pulse_width_transmitter and tx_line_checker.

module tb_ook_pulse_width_transmitter;
   import otx_pkg::*;

   localparam int RANDOM_ITEMS = 1650;
   localparam int STALL_LIMIT  = 1000;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b1;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   int   mismatch_count;
   int   pending_count;
   logic busy_predicted;
   bit   gaps_enabled = 1'b1;
   int   items_sent   = 0;
   int   quiet_cycles = 0;

   ook_pulse_width_transmitter uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tx_line_checker line_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .busy_predicted (busy_predicted)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic req_type tick_item();
      req_type r;
      r.opcode       = OP_TICK;
      r.code_word    = $urandom;
      r.bit_count    = COUNT_W'($urandom_range(0, 63));
      r.repeat_count = REPEAT_W'($urandom_range(0, 65535));
      return r;
   endfunction

   function automatic req_type start_item(input logic [CODE_W-1:0] code, input int count,
                                          input int reps);
      req_type r;
      r.opcode       = OP_START;
      r.code_word    = code;
      r.bit_count    = COUNT_W'(count);
      r.repeat_count = REPEAT_W'(reps);
      return r;
   endfunction

   function automatic cfg_type make_timing(input int p, input int sh, input int sl,
                                           input int oh, input int ol, input int zh,
                                           input int zl);
      cfg_type t;
      t.pulse_ticks     = PULSE_W'(p);
      t.sync_high_units = UNIT_W'(sh);
      t.sync_low_units  = UNIT_W'(sl);
      t.one_high_units  = UNIT_W'(oh);
      t.one_low_units   = UNIT_W'(ol);
      t.zero_high_units = UNIT_W'(zh);
      t.zero_low_units  = UNIT_W'(zl);
      return t;
   endfunction

   // Mostly short stretches so that many codes go out; a zero now and then acts as one.
   function automatic int random_units();
      return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
   endfunction

   function automatic cfg_type random_timing();
      int p;
      p = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      return make_timing(p, random_units(), random_units(), random_units(),
                         random_units(), random_units(), random_units());
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      if (gaps_enabled && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 18);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Ticks until the last frame is out, with the odd start thrown in to be rejected.
   task automatic run_until_idle();
      while (busy_predicted) begin
         if ($urandom_range(0, 39) == 0) begin
            send_item(start_item($urandom, $urandom_range(0, 63), $urandom_range(0, 65535)));
         end else begin
            send_item(tick_item());
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic apply_timing(input cfg_type t);
      logic [CSR_INDEX_W-1:0] regs[7];
      logic [CSR_DATA_W-1:0]  vals[7];
      regs = '{CSR_PULSE_TICKS, CSR_SYNC_HIGH_UNITS, CSR_SYNC_LOW_UNITS, CSR_ONE_HIGH_UNITS,
               CSR_ONE_LOW_UNITS, CSR_ZERO_HIGH_UNITS, CSR_ZERO_LOW_UNITS};
      vals = '{t.pulse_ticks, CSR_DATA_W'(t.sync_high_units), CSR_DATA_W'(t.sync_low_units),
               CSR_DATA_W'(t.one_high_units), CSR_DATA_W'(t.one_low_units),
               CSR_DATA_W'(t.zero_high_units), CSR_DATA_W'(t.zero_low_units)};
      for (int i = 0; i < 7; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= regs[i];
         csr_wdata    <= vals[i];
         @(negedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // Some noise, then one well-formed code sent to the end of its last frame.
   task automatic send_transmission(input bit long_units);
      int count;
      int reps;
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 2))
            0: send_item(tick_item());
            1: send_item(start_item($urandom,
                                    $urandom_range(0, 1) ? 0 : $urandom_range(MAX_BITS + 1, 63),
                                    $urandom_range(0, 65535)));
            default: send_item(start_item($urandom, $urandom_range(1, MAX_BITS), 0));
         endcase
      end
      if (long_units) begin
         count = $urandom_range(1, 2);
         reps  = 1;
      end else begin
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(9, MAX_BITS)
                                             : $urandom_range(1, 8);
         reps  = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
      end
      send_item(start_item($urandom, count, reps));
      run_until_idle();
   endtask

   initial begin
      int target;
      int phase_no;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero bit at the timing left by reset: its high stretch runs on the reset pulse
      // length, then the pulse unit drops to one tick and the unit counts stay as reset.
      send_item(start_item(32'h0, 1, 1));
      repeat (351) send_item(tick_item());
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PULSE_TICKS;
      csr_wdata    <= CSR_DATA_W'(1);
      @(negedge clock);
      csr_write_en <= 1'b0;
      run_until_idle();
      send_item(start_item(32'h1, 1, 1));
      run_until_idle();
      drain();

      // Directed: zero timing values, rejected starts, busy and a zero repeat count.
      apply_timing(make_timing(0, 0, 1, 2, 1, 1, 0));
      send_item(tick_item());
      send_item(start_item(32'hFFFF_FFFF, 0, 16'hFFFF));
      send_item(start_item(32'hFFFF_FFFF, MAX_BITS + 1, 1));
      send_item(start_item(32'h0, 63, 1));
      send_item(start_item(32'hFFFF_FFFF, MAX_BITS, 0));
      send_item(tick_item());
      send_item(start_item(32'h2, 2, 2));
      send_item(start_item(32'h5, 3, 1));
      send_item(start_item(32'h5, 0, 1));
      run_until_idle();
      send_item(tick_item());
      drain();

      target   = items_sent + RANDOM_ITEMS;
      phase_no = 0;
      while (items_sent < target) begin
         case (phase_no)
            0: begin
               apply_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
               send_item(start_item(32'hFFFF_FFFF, MAX_BITS, 2));
               run_until_idle();
            end
            1: apply_timing(make_timing(1, 63, 63, 63, 63, 63, 63));
            default: apply_timing(random_timing());
         endcase
         repeat ((phase_no == 1) ? 1 : 4) send_transmission(phase_no == 1);
         drain();
         phase_no++;
      end

      // A longer pulse unit to finish, with no gaps on either side.
      gaps_enabled = 1'b0;
      apply_timing(make_timing(48, 1, 1, 1, 1, 1, 1));
      send_item(start_item($urandom, 2, 1));
      run_until_idle();
      drain();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      @(negedge clock);
      forever begin
         if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
